// ===== hdl/pma_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Pooling unit package
// Shared word types, register indexes and sequencer codes of the 2-D
// max/average pooling unit.
// ----------------------------------------------------------------------------
package pma_pkg;

	// Input word: one Q8.8 pixel and its last-row flag.
	typedef struct packed {
		logic signed [15:0] pixel;
		logic               final_row;
	} pix_word_t;

	// Output word: one pooled result and its position.
	typedef struct packed {
		logic signed [15:0] pooled;
		logic [7:0]         out_row;
		logic [7:0]         out_col;
		logic               run_last;
	} pool_word_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_POOL_MODE   = 3'd0,
		REG_KERNEL_ROWS = 3'd1,
		REG_KERNEL_COLS = 3'd2,
		REG_STEP_ROWS   = 3'd3,
		REG_STEP_COLS   = 3'd4,
		REG_MARGIN_ROWS = 3'd5,
		REG_MARGIN_COLS = 3'd6,
		REG_PLANE_WIDTH = 3'd7
	} cfg_reg_t;

	// Signed coordinate type for window geometry.
	typedef logic signed [11:0] crd_t;

	// Accumulator width and divider step count.
	localparam int ACC_W    = 20;
	localparam int AREA_W   = 5;
	localparam int DIV_STEPS = ACC_W;

	// Sequencer states.
	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_SETUP  = 8'b0000_0010,
		S_WALK   = 8'b0000_0100,
		S_READ   = 8'b0000_1000,
		S_UPDATE = 8'b0001_0000,
		S_DIVIDE = 8'b0010_0000,
		S_PUSH   = 8'b0100_0000,
		S_FLUSH  = 8'b1000_0000
	} seq_state_t;

endpackage
`default_nettype wire

// ===== hdl/pma_divider.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Pooling unit divider
// Restoring divider, one quotient bit per cycle, for the average of a window.
// ----------------------------------------------------------------------------
module pma_divider (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [pma_pkg::ACC_W-1:0]  dividend,
	input  wire logic [pma_pkg::AREA_W-1:0] divisor,
	output logic                            done,
	output logic [pma_pkg::ACC_W-1:0]       quotient
);
	import pma_pkg::*;

	localparam int CNT_W = $clog2(DIV_STEPS + 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [ACC_W-1:0]  quo_q;
	logic [AREA_W:0]   rem_q;
	logic [AREA_W-1:0] div_q;
	logic [AREA_W:0]   rem_sh;
	logic              fits;

	// Shift in the next dividend bit and try the subtraction.
	always_comb begin
		rem_sh = {rem_q[AREA_W-1:0], quo_q[ACC_W-1]};
		fits   = (rem_sh >= {1'b0, div_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Quotient and remainder datapath.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[ACC_W-2:0], fits};
			rem_q <= fits ? (rem_sh - {1'b0, div_q}) : rem_sh;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

// ===== hdl/pool2d_max_average_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// 2-D max/average pooling unit
// Streams one channel plane in raster order and emits pooled windows.
// ----------------------------------------------------------------------------
// One pixel word is taken at a time; the input stalls until every window the
// pixel touches has been updated and all its results are handed on. A small
// sequencer walks the covering windows: the accepting state and set-up, then
// per window a step, a read of the window store and an update, for a closing
// window a hand-on of its result, plus a step per window row and a final step
// and flush. A closing window in average mode also waits in the bit-serial
// divider, and output stalls hold the hand-on of results.
// The window store keeps ACTIVE_POOL_ROWS pooled rows of MAX_WIDTH windows
// and needs no clearing: the first pixel of each window overwrites its slot.
// Configuration must be written only while idle; the block does not enforce it.
module pool2d_max_average_unit #(
	parameter int MAX_WIDTH        = 256,
	parameter int MAX_HEIGHT       = 256,
	parameter int ACTIVE_POOL_ROWS = 4
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire pma_pkg::pix_word_t in_word,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output pma_pkg::pool_word_t     out_word,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [8:0]         cfg_data
);
	import pma_pkg::*;

	localparam int WMAX  = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
	localparam int HMAX  = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;
	localparam int DEPTH = ACTIVE_POOL_ROWS * MAX_WIDTH;
	localparam int AW    = $clog2(DEPTH);
	localparam int SW    = (ACTIVE_POOL_ROWS > 1) ? $clog2(ACTIVE_POOL_ROWS) : 1;
	localparam int RECIP = (65536 + ACTIVE_POOL_ROWS - 1) / ACTIVE_POOL_ROWS;

	// Divide a small non-negative value by a stride of 1 to 4.
	function automatic crd_t div_s(input crd_t a, input logic [2:0] s);
		logic [21:0] prod;
		prod = 22'(unsigned'(a)) * 22'd683;
		unique case (s)
			3'd2:    return a >>> 1;
			3'd3:    return crd_t'(prod >> 11);
			3'd4:    return a >>> 2;
			default: return a;
		endcase
	endfunction

	// Pooled output length under the ceil rule.
	function automatic crd_t pooled_len(input crd_t n, input crd_t k, input logic [2:0] s,
			input crd_t p);
		crd_t a;
		crd_t q;
		crd_t len;
		a = n + p + p - k;
		if (a >= 0) q = div_s(a + crd_t'(s) - crd_t'(1), s);
		else q = -div_s(-a, s);
		len = q + crd_t'(1);
		if (p > 0 && q * crd_t'(s) >= n + p) len = len - crd_t'(1);
		return len;
	endfunction

	// First window whose span covers position x.
	function automatic crd_t first_cover(input crd_t x, input crd_t k, input logic [2:0] s,
			input crd_t p);
		crd_t t;
		t = x + p - k;
		return (t < 0) ? crd_t'(0) : div_s(t, s) + crd_t'(1);
	endfunction

	// Stored pooled row modulo the number of active rows.
	function automatic logic [SW-1:0] slot_of(input crd_t ph);
		logic [27:0] prod;
		logic [27:0] q;
		logic [27:0] rem;
		prod = 28'(unsigned'(ph[9:0])) * 28'(RECIP);
		q    = prod >> 16;
		rem  = 28'(unsigned'(ph[9:0])) - q * 28'(ACTIVE_POOL_ROWS);
		return SW'(rem);
	endfunction

	// Saturate a kernel or stride setting to 1..4.
	function automatic logic [2:0] sat_1_4(input logic [2:0] v);
		if (v == 3'd0) return 3'd1;
		if (v > 3'd4) return 3'd4;
		return v;
	endfunction

	// Configuration registers.
	logic       mode_q;
	logic [2:0] kr_cfg_q, kc_cfg_q, sr_cfg_q, sc_cfg_q;
	logic [1:0] pr_q, pc_q;
	logic [8:0] wid_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			kr_cfg_q <= 3'd2;
			kc_cfg_q <= 3'd2;
			sr_cfg_q <= 3'd2;
			sc_cfg_q <= 3'd2;
			pr_q     <= 2'd0;
			pc_q     <= 2'd0;
			wid_q    <= 9'd16;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_POOL_MODE:   mode_q   <= cfg_data[0];
				REG_KERNEL_ROWS: kr_cfg_q <= cfg_data[2:0];
				REG_KERNEL_COLS: kc_cfg_q <= cfg_data[2:0];
				REG_STEP_ROWS:   sr_cfg_q <= cfg_data[2:0];
				REG_STEP_COLS:   sc_cfg_q <= cfg_data[2:0];
				REG_MARGIN_ROWS: pr_q     <= cfg_data[1:0];
				REG_MARGIN_COLS: pc_q     <= cfg_data[1:0];
				REG_PLANE_WIDTH: wid_q    <= cfg_data;
			endcase
		end
	end

	// Effective geometry from the registers.
	logic [2:0] sr, sc;
	crd_t       kr, kc, pr, pc, w_c;

	always_comb begin
		kr = crd_t'(sat_1_4(kr_cfg_q));
		kc = crd_t'(sat_1_4(kc_cfg_q));
		sr = sat_1_4(sr_cfg_q);
		sc = sat_1_4(sc_cfg_q);
		pr = crd_t'(pr_q);
		pc = crd_t'(pc_q);
		if (wid_q == 9'd0) w_c = crd_t'(1);
		else if (int'(wid_q) > WMAX) w_c = crd_t'(WMAX);
		else w_c = crd_t'(wid_q);
	end

	// Sequencer and per-item registers.
	seq_state_t state_q;
	logic [7:0] row_q, col_q;
	logic signed [15:0] x_q;
	logic       fin_q;
	crd_t       w_q, r_q, c_q, pw_len_q, ph_len_q;
	crd_t       ph_hi_q, pw_lo_q, pw_hi_q, ph_q, pw_q;
	logic       first_q, emit_q, neg_q;
	logic [AREA_W-1:0] area_q;
	logic [AW-1:0]     addr_q;
	logic signed [15:0] res_q;
	pool_word_t hold_q;
	logic       hold_valid_q;
	pool_word_t out_q;
	logic       out_valid_q;

	// Set-up values for the accepted pixel.
	crd_t r_c, c_c;
	always_comb begin
		r_c = crd_t'(row_q);
		c_c = (crd_t'(col_q) > w_c - crd_t'(1)) ? w_c - crd_t'(1) : crd_t'(col_q);
	end

	// Geometry of the current window.
	crd_t hs, ws, wend, he, we, dh, dw;
	logic row_close, first_c, emit_c;
	logic [AREA_W-1:0] area_c;
	logic [AW-1:0]     addr_c;

	always_comb begin
		hs   = ph_q * crd_t'(sr) - pr;
		ws   = pw_q * crd_t'(sc) - pc;
		wend = (ws + kc < w_q) ? ws + kc : w_q;
		row_close = fin_q ? (ph_q < ph_len_q) : (hs + kr - crd_t'(1) == r_q);
		first_c = (r_q == ((hs > 0) ? hs : crd_t'(0))) &&
			(c_q == ((ws > 0) ? ws : crd_t'(0)));
		emit_c = row_close && (c_q == wend - crd_t'(1));
		he = fin_q ? r_q + crd_t'(1) + pr : hs + kr;
		if (hs + kr < he) he = hs + kr;
		we = (ws + kc < w_q + pc) ? ws + kc : w_q + pc;
		dh = he - hs;
		dw = we - ws;
		area_c = AREA_W'(dh[2:0] * dw[2:0]);
		if (area_c == '0) area_c = AREA_W'(1);
		addr_c = AW'(32'(slot_of(ph_q)) * 32'(MAX_WIDTH) + 32'(unsigned'(pw_q[9:0])));
	end

	// Window store: running max or sum per open window.
	logic signed [ACC_W-1:0] acc_mem [DEPTH];
	logic signed [ACC_W-1:0] mem_rd_q;
	logic signed [ACC_W-1:0] acc_new;
	logic signed [ACC_W-1:0] x_ext;
	logic                    mem_we;

	assign mem_we = (state_q == S_UPDATE);

	always_ff @(posedge clk) begin
		if (mem_we) acc_mem[addr_q] <= acc_new;
		mem_rd_q <= acc_mem[addr_c];
	end

	// Update of the window value with the pixel.
	always_comb begin
		x_ext = ACC_W'(x_q);
		if (first_q) acc_new = x_ext;
		else if (mode_q) acc_new = mem_rd_q + x_ext;
		else acc_new = (x_ext > mem_rd_q) ? x_ext : mem_rd_q;
	end

	// Average of a closing window.
	logic              div_start, div_done;
	logic [ACC_W-1:0]  div_quo;
	logic [ACC_W-1:0]  acc_mag;
	logic [ACC_W-1:0]  avg_val;

	assign acc_mag   = acc_new[ACC_W-1] ? ACC_W'(-acc_new) : ACC_W'(acc_new);
	assign div_start = (state_q == S_UPDATE) && emit_q && mode_q;
	assign avg_val   = neg_q ? ACC_W'(-div_quo) : div_quo;

	pma_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (acc_mag),
		.divisor  (area_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Result handover.
	logic       out_free, load_out, end_item;
	pool_word_t new_res;

	always_comb begin
		out_free = !out_valid_q || !out_stall;
		new_res  = '{pooled: res_q, out_row: ph_q[7:0], out_col: pw_q[7:0], run_last: 1'b0};
		load_out = ((state_q == S_PUSH) || (state_q == S_FLUSH)) && hold_valid_q && out_free;
		end_item = (state_q == S_FLUSH) && (!hold_valid_q || out_free);
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			row_q        <= '0;
			col_q        <= '0;
			hold_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_SETUP;
				end
				S_SETUP: begin
					state_q <= S_WALK;
				end
				S_WALK: begin
					if (ph_q > ph_hi_q || ph_q >= crd_t'(256)) state_q <= S_FLUSH;
					else if (!(pw_q > pw_hi_q || pw_q >= pw_len_q || pw_q >= crd_t'(WMAX)))
						state_q <= S_READ;
				end
				S_READ: begin
					state_q <= S_UPDATE;
				end
				S_UPDATE: begin
					if (!emit_q) state_q <= S_WALK;
					else if (mode_q) state_q <= S_DIVIDE;
					else state_q <= S_PUSH;
				end
				S_DIVIDE: begin
					if (div_done) state_q <= S_PUSH;
				end
				S_PUSH: begin
					if (!hold_valid_q || out_free) begin
						hold_valid_q <= 1'b1;
						state_q      <= S_WALK;
					end
				end
				S_FLUSH: begin
					if (end_item) begin
						hold_valid_q <= 1'b0;
						state_q      <= S_IDLE;
						if (c_q >= w_q - crd_t'(1)) begin
							col_q <= '0;
							if (fin_q || int'(row_q) + 1 >= HMAX) row_q <= '0;
							else row_q <= row_q + 8'd1;
						end else begin
							col_q <= 8'(c_q + crd_t'(1));
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Per-item datapath registers.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			x_q   <= in_word.pixel;
			fin_q <= in_word.final_row;
		end
		if (state_q == S_SETUP) begin
			w_q      <= w_c;
			r_q      <= r_c;
			c_q      <= c_c;
			pw_len_q <= pooled_len(w_c, kc, sc, pc);
			ph_len_q <= pooled_len(r_c + crd_t'(1), kr, sr, pr);
			ph_hi_q  <= div_s(r_c + pr, sr);
			pw_lo_q  <= first_cover(c_c, kc, sc, pc);
			pw_hi_q  <= div_s(c_c + pc, sc);
			ph_q     <= first_cover(r_c, kr, sr, pr);
			pw_q     <= first_cover(c_c, kc, sc, pc);
		end
		if (state_q == S_WALK && !(ph_q > ph_hi_q || ph_q >= crd_t'(256)) &&
				(pw_q > pw_hi_q || pw_q >= pw_len_q || pw_q >= crd_t'(WMAX))) begin
			ph_q <= ph_q + crd_t'(1);
			pw_q <= pw_lo_q;
		end
		if (state_q == S_READ) begin
			first_q <= first_c;
			emit_q  <= emit_c;
			area_q  <= area_c;
			addr_q  <= addr_c;
		end
		if (state_q == S_UPDATE) begin
			neg_q <= acc_new[ACC_W-1];
			res_q <= acc_new[15:0];
			if (!emit_q) pw_q <= pw_q + crd_t'(1);
		end
		if (state_q == S_DIVIDE && div_done) res_q <= avg_val[15:0];
		if (state_q == S_PUSH && (!hold_valid_q || out_free)) begin
			hold_q <= new_res;
			pw_q   <= pw_q + crd_t'(1);
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= '{pooled: hold_q.pooled, out_row: hold_q.out_row,
				out_col: hold_q.out_col, run_last: (state_q == S_FLUSH)};
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_word  = out_q;

endmodule
`default_nettype wire
